FILE: rtl/core/mi4_pkg.sv
// Shared types, widths and constant tables of the 4x4 matrix inverse block.
package mi4_pkg;

  localparam int ELEM_W          = 16;  // Q8.8 matrix element
  localparam int POS_W           = 4;   // row*4+column
  localparam int MIN_W           = 33;  // exact 2x2 minor
  localparam int MUL_W           = 34;  // shared multiplier operand
  localparam int PROD_W          = 2 * MUL_W;
  localparam int ADJ_W           = 50;  // exact adjugate entry
  localparam int DET_W           = 68;  // exact determinant, signed
  localparam int OUT_W           = 32;  // Q16.16 result
  localparam int QUO_W           = 34;  // quotient bits formed by the divider
  localparam int FRAC_SHIFT      = 24;  // adjugate scale to Q16.16 scale
  localparam int NUM_SPLIT       = QUO_W - FRAC_SHIFT;
  localparam int NUM_MINORS      = 6;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [OUT_W-1:0] SAT_POS = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] SAT_NEG = {1'b1, {(OUT_W-1){1'b0}}};

  typedef struct packed {
    logic signed [ELEM_W-1:0] elem;
    logic [POS_W-1:0]         pos;
    logic                     last;
  } mi4_entry_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_MINOR,
    ST_DET,
    ST_DPREP,
    ST_ADJ,
    ST_APREP,
    ST_DCHK,
    ST_DIV,
    ST_ROUND,
    ST_EMIT
  } mi4_state_t;

  // Column pair of each 2x2 minor.
  function automatic logic [1:0] pair_col_a(input logic [2:0] p);
    logic [1:0] c;
    case (p)
      3'd0, 3'd1, 3'd2: c = 2'd0;
      3'd3, 3'd4:       c = 2'd1;
      default:          c = 2'd2;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] pair_col_b(input logic [2:0] p);
    logic [1:0] c;
    case (p)
      3'd0:       c = 2'd1;
      3'd1, 3'd3: c = 2'd2;
      default:    c = 2'd3;
    endcase
    return c;
  endfunction

  // Minor used by cofactor term t of row r.
  function automatic logic [2:0] minor_sel(input logic [1:0] r, input logic [1:0] t);
    logic [2:0] m;
    case ({r, t})
      4'b0000: m = 3'd5;
      4'b0001: m = 3'd4;
      4'b0010: m = 3'd3;
      4'b0100: m = 3'd5;
      4'b0101: m = 3'd2;
      4'b0110: m = 3'd1;
      4'b1000: m = 3'd4;
      4'b1001: m = 3'd2;
      4'b1010: m = 3'd0;
      4'b1100: m = 3'd3;
      4'b1101: m = 3'd1;
      4'b1110: m = 3'd0;
      default: m = 3'd0;
    endcase
    return m;
  endfunction

  // Terms of the Laplace expansion that are subtracted.
  function automatic logic det_term_neg(input logic [2:0] i);
    return (i == 3'd1) || (i == 3'd4);
  endfunction

endpackage

FILE: rtl/core/mi4_front.sv
// Input side: accepts elements and tags each with its matrix position.
module mi4_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [mi4_pkg::ELEM_W-1:0] in_element_in,
  input  logic                       q_full,
  output logic                       push,
  output mi4_pkg::mi4_entry_t        push_entry
);
  import mi4_pkg::*;

  logic [POS_W-1:0] load_cnt_r;
  logic [POS_W-1:0] load_cnt_nxt;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_entry.elem = in_element_in;
    push_entry.pos  = load_cnt_r;
    push_entry.last = (load_cnt_r == {POS_W{1'b1}});
    load_cnt_nxt    = push ? load_cnt_r + POS_W'(1) : load_cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_cnt_r <= '0;
    end else begin
      load_cnt_r <= load_cnt_nxt;
    end
  end

endmodule

FILE: rtl/core/mi4_queue.sv
// Short element queue between the input side and the compute engine.
module mi4_queue #(
  parameter int DEPTH = mi4_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  mi4_pkg::mi4_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output logic                q_valid,
  output mi4_pkg::mi4_entry_t pop_entry
);
  import mi4_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mi4_entry_t       slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign q_valid   = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && q_valid;
  assign pop_entry = slot_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wrap_inc(wr_ptr_r);
      if (do_pop)  rd_ptr_r <= wrap_inc(rd_ptr_r);
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + CNT_W'(1);
        2'b01:   count_r <= count_r - CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

FILE: rtl/core/mi4_back.sv
// Compute engine: minors, determinant, adjugate, exact division and result register.
module mi4_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  mi4_pkg::mi4_entry_t          pop_entry,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [mi4_pkg::OUT_W-1:0]    out_element_out,
  output logic [mi4_pkg::POS_W-1:0]    out_position,
  output logic                         out_singular,
  output logic                         out_saturated,
  output logic                         out_last
);
  import mi4_pkg::*;

  localparam int BIT_W = $clog2(QUO_W);

  mi4_state_t state_r, state_nxt;

  logic signed [ELEM_W-1:0] mat_r [16];
  logic signed [MIN_W-1:0]  upper_r [NUM_MINORS];
  logic signed [MIN_W-1:0]  lower_r [NUM_MINORS];
  logic signed [ELEM_W-1:0] a_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ADJ_W-1:0]  acc_r;
  logic signed [DET_W-1:0]  det_r;
  logic [DET_W-1:0]         dmag_r;
  logic                     dneg_r, sing_r, neg_r;
  logic [DET_W:0]           rem_r;
  logic [QUO_W-1:0]         nlo_r, q_r;
  logic [OUT_W-1:0]         res_val_r;
  logic                     res_sat_r;
  logic [2:0]               step_r;
  logic [3:0]               cnt_r;
  logic [POS_W-1:0]         k_r;
  logic [BIT_W-1:0]         bit_r;
  logic                     out_valid_r, out_sing_r, out_sat_r, out_last_r;
  logic [OUT_W-1:0]         out_val_r;
  logic [POS_W-1:0]         out_pos_r;

  logic                     load_ok, emit_go;
  logic [3:0]               rd_addr;
  logic signed [ELEM_W-1:0] elem_rd;
  logic                     minor_hi;
  logic [2:0]               pair;
  logic [1:0]               pa, pb, adj_row, col_j, srow, term, adj_col;
  logic [2:0]               msel;
  logic signed [MIN_W-1:0]  mn;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [ADJ_W-1:0]  adj_fin;
  logic [ADJ_W-1:0]         adj_mag;
  logic [DET_W:0]           dmag_ext, trial;
  logic                     fits, rnd, too_big;
  logic [QUO_W:0]           q_rnd, limit;

  assign load_ok = !out_valid_r || !out_stall;

  // Next state and handshake
  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    emit_go   = 1'b0;
    case (state_r)
      ST_LOAD: begin
        pop = q_valid;
        if (q_valid && pop_entry.last) state_nxt = ST_MINOR;
      end
      ST_MINOR: if (step_r == 3'd5 && cnt_r == 4'd11) state_nxt = ST_DET;
      ST_DET:   if (step_r == 3'd1 && cnt_r == 4'd5) state_nxt = ST_DPREP;
      ST_DPREP: state_nxt = ST_ADJ;
      ST_ADJ:   if (step_r == 3'd2 && cnt_r == 4'd2) state_nxt = ST_APREP;
      ST_APREP: state_nxt = ST_DCHK;
      ST_DCHK:  state_nxt = (sing_r || rem_r >= dmag_ext) ? ST_EMIT : ST_DIV;
      ST_DIV:   if (bit_r == BIT_W'(QUO_W - 1)) state_nxt = ST_ROUND;
      ST_ROUND: state_nxt = ST_EMIT;
      ST_EMIT: begin
        emit_go = load_ok;
        if (load_ok) state_nxt = (k_r == {POS_W{1'b1}}) ? ST_LOAD : ST_ADJ;
      end
      default:  state_nxt = ST_LOAD;
    endcase
  end

  // Operand selection
  always_comb begin
    minor_hi = (cnt_r >= 4'd6);
    pair     = minor_hi ? cnt_r[2:0] - 3'd6 : cnt_r[2:0];
    pa       = pair_col_a(pair);
    pb       = pair_col_b(pair);
    adj_row  = k_r[3:2];
    col_j    = k_r[1:0];
    srow     = col_j ^ 2'd1;
    term     = cnt_r[1:0];
    adj_col  = (term < adj_row) ? term : term + 2'd1;
    msel     = minor_sel(adj_row, term);
    mn       = (col_j < 2'd2) ? lower_r[msel] : upper_r[msel];
    rd_addr  = {srow, adj_col};
    if (state_r == ST_MINOR) begin
      case (step_r)
        3'd0:    rd_addr = {minor_hi, 1'b0, pa};
        3'd1:    rd_addr = {minor_hi, 1'b1, pb};
        3'd2:    rd_addr = {minor_hi, 1'b1, pa};
        default: rd_addr = {minor_hi, 1'b0, pb};
      endcase
    end
    elem_rd = mat_r[rd_addr];
    case (state_r)
      ST_DET: begin
        mul_a = MUL_W'(upper_r[cnt_r[2:0]]);
        mul_b = MUL_W'(lower_r[3'd5 - cnt_r[2:0]]);
      end
      ST_ADJ: begin
        mul_a = MUL_W'(a_r);
        mul_b = MUL_W'(mn);
      end
      default: begin
        mul_a = MUL_W'(a_r);
        mul_b = MUL_W'(elem_rd);
      end
    endcase
    adj_fin  = (k_r[2] ^ k_r[0]) ? -acc_r : acc_r;
    adj_mag  = adj_fin[ADJ_W-1] ? ADJ_W'(-adj_fin) : ADJ_W'(adj_fin);
    dmag_ext = {1'b0, dmag_r};
    trial    = {rem_r[DET_W-1:0], nlo_r[QUO_W-1]};
    fits     = (trial >= dmag_ext);
    rnd      = ({rem_r[DET_W-1:0], 1'b0} >= dmag_ext);
    q_rnd    = {1'b0, q_r} + (QUO_W+1)'(rnd);
    limit    = neg_r ? (QUO_W+1)'(SAT_NEG) : (QUO_W+1)'(SAT_POS);
    too_big  = (q_rnd > limit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencer counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      cnt_r  <= '0;
      k_r    <= '0;
      bit_r  <= '0;
    end else begin
      case (state_r)
        ST_LOAD: begin
          step_r <= '0;
          cnt_r  <= '0;
          k_r    <= '0;
        end
        ST_MINOR: begin
          if (step_r == 3'd5) begin
            step_r <= '0;
            cnt_r  <= (cnt_r == 4'd11) ? 4'd0 : cnt_r + 4'd1;
          end else begin
            step_r <= step_r + 3'd1;
          end
        end
        ST_DET: begin
          if (step_r == 3'd1) begin
            step_r <= '0;
            cnt_r  <= (cnt_r == 4'd5) ? 4'd0 : cnt_r + 4'd1;
          end else begin
            step_r <= step_r + 3'd1;
          end
        end
        ST_ADJ: begin
          if (step_r == 3'd2) begin
            step_r <= '0;
            cnt_r  <= (cnt_r == 4'd2) ? 4'd0 : cnt_r + 4'd1;
          end else begin
            step_r <= step_r + 3'd1;
          end
        end
        ST_DCHK: bit_r <= '0;
        ST_DIV:  bit_r <= bit_r + BIT_W'(1);
        ST_EMIT: if (load_ok) k_r <= k_r + POS_W'(1);
        default: ;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_LOAD: begin
        if (q_valid) mat_r[pop_entry.pos] <= pop_entry.elem;
      end
      ST_MINOR: begin
        case (step_r)
          3'd0: a_r <= elem_rd;
          3'd1: prod_r <= mul_a * mul_b;
          3'd2: begin
            acc_r <= ADJ_W'(prod_r);
            a_r   <= elem_rd;
          end
          3'd3: prod_r <= mul_a * mul_b;
          3'd4: acc_r <= acc_r - ADJ_W'(prod_r);
          default: begin
            if (minor_hi) lower_r[pair] <= MIN_W'(acc_r);
            else          upper_r[pair] <= MIN_W'(acc_r);
          end
        endcase
        det_r <= '0;
      end
      ST_DET: begin
        if (step_r == 3'd0) begin
          prod_r <= mul_a * mul_b;
        end else if (det_term_neg(cnt_r[2:0])) begin
          det_r <= det_r - DET_W'(prod_r);
        end else begin
          det_r <= det_r + DET_W'(prod_r);
        end
      end
      ST_DPREP: begin
        dneg_r <= det_r[DET_W-1];
        dmag_r <= det_r[DET_W-1] ? DET_W'(-det_r) : DET_W'(det_r);
        sing_r <= (det_r == '0);
        acc_r  <= '0;
      end
      ST_ADJ: begin
        case (step_r)
          3'd0:    a_r <= elem_rd;
          3'd1:    prod_r <= mul_a * mul_b;
          default: acc_r <= (term == 2'd1) ? acc_r - ADJ_W'(prod_r)
                                           : acc_r + ADJ_W'(prod_r);
        endcase
      end
      ST_APREP: begin
        neg_r <= adj_fin[ADJ_W-1] ^ dneg_r;
        rem_r <= (DET_W+1)'(adj_mag[ADJ_W-1:NUM_SPLIT]);
        nlo_r <= {adj_mag[NUM_SPLIT-1:0], {FRAC_SHIFT{1'b0}}};
      end
      ST_DCHK: begin
        q_r <= '0;
        if (sing_r) begin
          res_val_r <= '0;
          res_sat_r <= 1'b0;
        end else begin
          // quotient at least 2^34: clip without dividing
          res_val_r <= neg_r ? SAT_NEG : SAT_POS;
          res_sat_r <= 1'b1;
        end
      end
      ST_DIV: begin
        rem_r <= fits ? trial - dmag_ext : trial;
        q_r   <= {q_r[QUO_W-2:0], fits};
        nlo_r <= {nlo_r[QUO_W-2:0], 1'b0};
      end
      ST_ROUND: begin
        if (too_big) begin
          res_val_r <= neg_r ? SAT_NEG : SAT_POS;
          res_sat_r <= 1'b1;
        end else begin
          res_val_r <= neg_r ? OUT_W'(-q_rnd[OUT_W-1:0]) : q_rnd[OUT_W-1:0];
          res_sat_r <= 1'b0;
        end
      end
      ST_EMIT: begin
        acc_r <= '0;
      end
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_val_r  <= res_val_r;
      out_pos_r  <= k_r;
      out_sing_r <= sing_r;
      out_sat_r  <= res_sat_r;
      out_last_r <= (k_r == {POS_W{1'b1}});
    end
  end

  assign out_valid       = out_valid_r;
  assign out_element_out = out_val_r;
  assign out_position    = out_pos_r;
  assign out_singular    = out_sing_r;
  assign out_saturated   = out_sat_r;
  assign out_last        = out_last_r;

`ifndef SYNTHESIS
  a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < dmag_ext))
    else $error("divider remainder not below divisor");

  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_sing_r) |-> (out_val_r == '0 && !out_sat_r))
    else $error("singular result not zero");

  a_last_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD && q_valid && pop_entry.last) |=> (state_r == ST_MINOR))
    else $error("full matrix did not start compute");

  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_go && k_r == {POS_W{1'b1}}) |=> (state_r == ST_LOAD && out_last_r))
    else $error("run did not end after sixteenth result");
`endif

endmodule

FILE: rtl/core/matrix_inverse_4x4_top.sv
// Top level of the 4x4 matrix inverse: input side, element queue and compute engine.
// Load sixteen Q8.8 elements in row-major order; the block then returns the sixteen Q16.16
// elements of the inverse in row-major order, each rounded to nearest (ties away from zero)
// and clipped, with a singular flag on an all-zero result for a zero determinant. The
// block first forms the minors, then the determinant, and then for each result the
// adjugate entry and a division by the one-bit-per-cycle restoring divider; a result
// of a singular matrix, or one clipped before dividing, skips the divider. The queue
// takes up to QUEUE_DEPTH elements of the next matrix while the current one is computed.
module matrix_inverse_4x4_top #(
  parameter int QUEUE_DEPTH = mi4_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [mi4_pkg::ELEM_W-1:0] in_element_in,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [mi4_pkg::OUT_W-1:0]  out_element_out,
  output logic [mi4_pkg::POS_W-1:0]         out_position,
  output logic                              out_singular,
  output logic                              out_saturated,
  output logic                              out_last
);
  import mi4_pkg::*;

  mi4_entry_t push_entry, pop_entry;
  logic       push, q_full, pop, q_valid;
  logic [OUT_W-1:0] element_bits;

  mi4_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_element_in(in_element_in),
    .q_full       (q_full),
    .push         (push),
    .push_entry   (push_entry)
  );

  mi4_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_entry(push_entry),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .pop_entry (pop_entry)
  );

  mi4_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .pop_entry      (pop_entry),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_element_out(element_bits),
    .out_position   (out_position),
    .out_singular   (out_singular),
    .out_saturated  (out_saturated),
    .out_last       (out_last)
  );

  assign out_element_out = signed'(element_bits);

endmodule

FILE: tb/sv/tb_top.sv
// Testbench of the 4x4 matrix inverse: streamed matrices checked against an exact predictor.
module tb_top;
  import mi4_pkg::*;

  localparam int NUM_MATS  = 30;
  localparam int HOLD_MAT  = 6;
  localparam int DRAIN_MAT = 12;
  localparam int HOLD_LEN  = 3000;

  typedef struct packed {
    logic signed [OUT_W-1:0] value;
    logic [POS_W-1:0]        pos;
    logic                    singular;
    logic                    saturated;
    logic                    last;
  } inv_elem_t;

  typedef struct {
    logic signed [ELEM_W-1:0] elems[16];
    logic signed [OUT_W-1:0]  diag;
    logic                     singular;
  } known_mat_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [ELEM_W-1:0] in_element_in = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [OUT_W-1:0]  out_element_out;
  logic [POS_W-1:0]         out_position;
  logic                     out_singular;
  logic                     out_saturated;
  logic                     out_last;

  inv_elem_t inverse_q[$];
  int        mismatches = 0;
  int        n_results = 0, n_singular = 0, n_saturated = 0, n_items = 0;
  bit        quiet = 1'b0;
  bit        hold_req = 1'b0;

  logic signed [ELEM_W-1:0] load_buf[16];
  int                       load_idx = 0;

  matrix_inverse_4x4_top u_dut (.*);

  always #6 clk = ~clk;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  // Exact adjugate over determinant for the matrix in load_buf.
  function automatic void predict_inverse();
    int        pa[6] = '{0, 0, 0, 1, 1, 2};
    int        pb[6] = '{1, 2, 3, 2, 3, 3};
    int        msel[4][3] = '{'{5, 4, 3}, '{5, 2, 1}, '{4, 2, 0}, '{3, 1, 0}};
    longint    up[6], lo[6], mn[6];
    logic signed [127:0] det, term128;
    logic [127:0] dmag, num, quo, rem, limit;
    longint    adj, term, mag;
    bit        dneg, sing, neg;
    int        r, j, col;
    inv_elem_t res;
    for (int i = 0; i < 6; i++) begin
      up[i] = longint'(load_buf[pa[i]]) * longint'(load_buf[4 + pb[i]])
            - longint'(load_buf[4 + pa[i]]) * longint'(load_buf[pb[i]]);
      lo[i] = longint'(load_buf[8 + pa[i]]) * longint'(load_buf[12 + pb[i]])
            - longint'(load_buf[12 + pa[i]]) * longint'(load_buf[8 + pb[i]]);
    end
    det = '0;
    for (int i = 0; i < 6; i++) begin
      term128 = up[i] * lo[5 - i];
      det = (i == 1 || i == 4) ? det - term128 : det + term128;
    end
    dneg = det[127];
    dmag = dneg ? -det : det;
    sing = (det == 0);
    for (int k = 0; k < 16; k++) begin
      r = k >> 2;
      j = k & 3;
      if (j < 2) mn = lo;
      else       mn = up;
      adj = 0;
      col = 0;
      for (int t = 0; t < 3; t++) begin
        if (col == r) col++;
        term = longint'(load_buf[(j ^ 1) * 4 + col]) * mn[msel[r][t]];
        adj = (t == 1) ? adj - term : adj + term;
        col++;
      end
      if ((r + j) & 1) adj = -adj;
      res = '{value: '0, pos: k[3:0], singular: sing, saturated: 1'b0, last: (k == 15)};
      if (!sing) begin
        neg = (adj < 0) != dneg;
        mag = (adj < 0) ? -adj : adj;
        num = 128'(mag) << FRAC_SHIFT;
        quo = num / dmag;
        rem = num % dmag;
        if ((rem << 1) >= dmag) quo++;
        limit = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (quo > limit) begin
          res.saturated = 1'b1;
          res.value = neg ? SAT_NEG : SAT_POS;
        end else begin
          res.value = neg ? -quo[31:0] : quo[31:0];
        end
      end
      inverse_q.push_back(res);
    end
  endfunction

  // Drive one element and hold it until the transfer.
  task automatic send_element(input logic signed [ELEM_W-1:0] e);
    @(negedge clk);
    in_valid <= 1'b1;
    in_element_in <= e;
    do @(posedge clk); while (in_stall);
    n_items++;
    load_buf[load_idx] = e;
    load_idx++;
  endtask

  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 4)) @(negedge clk);
    end
  endtask

  function automatic logic signed [ELEM_W-1:0] pick_extreme();
    case ($urandom_range(0, 4))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh0000;
      3: return 16'sh0100;
      default: return 16'shFFFF;
    endcase
  endfunction

  // Random matrix: full range, small, near-singular, singular, extremes or near-diagonal.
  task automatic make_matrix(output logic signed [ELEM_W-1:0] m[16]);
    int kind = $urandom_range(0, 5);
    int src, dst;
    for (int i = 0; i < 16; i++) begin
      case (kind)
        1: m[i] = $signed(16'($urandom_range(0, 1023))) - 16'sd512;
        4: m[i] = pick_extreme();
        5: m[i] = ((i % 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15));
        default: m[i] = 16'($urandom);
      endcase
    end
    if (kind == 2 || kind == 3) begin
      src = $urandom_range(0, 3);
      dst = (src + $urandom_range(1, 3)) % 4;
      for (int c = 0; c < 4; c++)
        m[dst * 4 + c] = m[src * 4 + c]
                       + ((kind == 2) ? 16'($urandom_range(0, 2)) : 16'sd0);
    end
  endtask

  known_mat_t known[3];

  initial begin
    logic signed [ELEM_W-1:0] m[16];
    inv_elem_t e;
    for (int i = 0; i < 16; i++) begin
      known[0].elems[i] = ((i % 5) == 0) ? 16'sh0100 : 16'sh0000;  // identity
      known[1].elems[i] = 16'sh0000;                                // all zero
      known[2].elems[i] = ((i % 5) == 0) ? 16'sh8000 : 16'sh0000;  // -128 on the diagonal
    end
    known[0].diag = 32'sh0001_0000; known[0].singular = 1'b0;
    known[1].diag = 32'sh0000_0000; known[1].singular = 1'b1;
    known[2].diag = 32'shFFFF_FE00; known[2].singular = 1'b0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (known[d]) begin
      for (int i = 0; i < 16; i++) send_element(known[d].elems[i]);
      load_idx = 0;
      for (int k = 0; k < 16; k++) begin
        e.value = ((k % 5) == 0) ? known[d].diag : 32'sh0;
        e.pos = k[3:0];
        e.singular = known[d].singular;
        e.saturated = 1'b0;
        e.last = (k == 15);
        inverse_q.push_back(e);
      end
    end

    for (int n = 3; n < NUM_MATS; n++) begin
      if (n == HOLD_MAT) hold_req = 1'b1;
      if (n == DRAIN_MAT) begin
        @(negedge clk);
        in_valid <= 1'b0;
        while (inverse_q.size() != 0) @(posedge clk);
      end
      if (n >= NUM_MATS - 4) quiet = 1'b1;
      make_matrix(m);
      for (int i = 0; i < 16; i++) begin
        sender_gap();
        send_element(m[i]);
      end
      load_idx = 0;
      predict_inverse();
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (inverse_q.size() != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
    $display("ran %0d matrices (%0d elements): %0d results, %0d singular, %0d clipped",
             NUM_MATS, n_items, n_results, n_singular, n_saturated);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end

  // Receiver: random stall bursts, one long hold-off, none at the end.
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        for (int c = 0; c < HOLD_LEN; c++) @(negedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(negedge clk);
        out_stall <= 1'b0;
        repeat ($urandom_range(0, 8)) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Check each result transfer against the oldest expectation.
  always @(posedge clk) begin
    inv_elem_t e;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (inverse_q.size() == 0) begin
        report($sformatf("unexpected result at position %0d", out_position));
      end else begin
        e = inverse_q.pop_front();
        if (out_singular) n_singular++;
        if (out_saturated) n_saturated++;
        if (out_element_out !== e.value)
          report($sformatf("element %0d: got %h, want %h", e.pos, out_element_out, e.value));
        if (out_position !== e.pos)
          report($sformatf("position: got %0d, want %0d", out_position, e.pos));
        if (out_singular !== e.singular)
          report($sformatf("singular at %0d: got %b", e.pos, out_singular));
        if (out_saturated !== e.saturated)
          report($sformatf("saturated at %0d: got %b", e.pos, out_saturated));
        if (out_last !== e.last)
          report($sformatf("last at %0d: got %b", e.pos, out_last));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", inverse_q.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
